[src/pcg_pkg.sv]
// Shared types, constants and command structures of the proximity cost grid.
package pcg_pkg;

  localparam int MAX_RECTS = 32;
  localparam int MAX_COLS  = 128;
  localparam int MAX_ROWS  = 128;

  localparam int RECT_AW    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int RECT_CW    = $clog2(MAX_RECTS + 1);
  localparam int COL_AW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_AW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int GRID_AW    = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;

  localparam int ACT_W      = 2;
  localparam int SLOT_W     = 5;
  localparam int COORD_W    = 16;
  localparam int CELL_W     = 7;
  localparam int COST_W     = 24;
  localparam int GRAD_W     = 29;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int RECT_W     = 4 * COORD_W;

  localparam int CRD_W       = 20;
  localparam int SQ_W        = 2 * CRD_W;
  localparam int RAD_W       = SQ_W + 2;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);
  localparam int SREM_W      = ROOT_W + 3;
  localparam int DIV_NUM_W   = 32;
  localparam int DIV_DEN_W   = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BARRIER_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_COST     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_COST      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DIST     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_DIST      = 3'd7;

  localparam logic [7:0]  RST_CELL_SIZE = 8'd10;
  localparam logic [15:0] RST_NEAR_COST = 16'd10000;
  localparam logic [15:0] RST_FAR_COST  = 16'd1;
  localparam logic [15:0] RST_NEAR_DIST = 16'd80;
  localparam logic [15:0] RST_FAR_DIST  = 16'd1280;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_COMPUTE = 2'd1,
    ACT_COST    = 2'd2,
    ACT_GRAD    = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CELL  = 2'd0,
    KIND_POINT = 2'd1,
    KIND_GRAD  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    DIV_T  = 3'd0,
    DIV_PX = 3'd1,
    DIV_PY = 3'd2,
    DIV_GX = 3'd3,
    DIV_GY = 3'd4
  } div_sel_e;

  typedef enum logic [1:0] {
    SRC_NEAR = 2'd0,
    SRC_FAR  = 2'd1,
    SRC_MIX  = 2'd2,
    SRC_GRID = 2'd3
  } cost_src_e;

  typedef struct packed {
    logic      capture;
    logic      rect_we;
    logic      init_cell;
    logic      dist_calc;
    logic      sqrt_init;
    logic      sqrt_step;
    logic      min_upd;
    logic      div_start;
    div_sel_e  div_sel;
    logic      t_load;
    logic      t2_calc;
    logic      s_calc;
    logic      mix_calc;
    logic      cost_load;
    cost_src_e cost_src;
    logic      grid_we;
    logic      probe_init;
    logic      ix_load;
    logic      iy_load;
    logic      pc_load;
    logic      gx_load;
    logic      gy_load;
    logic      res_load;
  } pcg_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic grid_empty;
    logic rect_more;
    logic sqrt_last;
    logic best_lt_near;
    logic best_ge_far;
    logic div_done;
    logic div_busy;
    logic probe_last;
    logic is_grad;
  } pcg_status_t;

endpackage

[src/proximity_cost_grid.sv]
// Top level of the proximity cost grid: controller, datapath and configuration port.
//
// Input transactions carry an action: a load stores one rectangle and gives no
// result; a compute finds the nearest loaded rectangle to a cell corner, maps the
// distance to a cost, writes it into the grid if the cell lies inside, and
// returns it; a cost query returns the stored cost of the cell holding a point;
// a gradient query returns central differences of four probed cells.
// One transaction is processed at a time. A compute runs the one-bit-per-cycle
// square root once per rectangle and then maps the distance to a cost. Cost and
// gradient queries use the shared one-bit-per-cycle divider to locate each
// probed cell.
// Results sit in an output register, so a new transaction is accepted while a
// result waits; if the receiver stalls, the next result waits in its last state.
// Configuration writes are always accepted and must only occur when idle.
// Reset restores the configuration defaults; rectangle and grid memories are not
// cleared and must be written before they are read.
module proximity_cost_grid (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pcg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pcg_pkg::ACT_W-1:0]         action_i,
  input  logic [pcg_pkg::SLOT_W-1:0]        slot_i,
  input  logic [pcg_pkg::COORD_W-1:0]       rect_left_i,
  input  logic [pcg_pkg::COORD_W-1:0]       rect_top_i,
  input  logic [pcg_pkg::COORD_W-1:0]       rect_width_i,
  input  logic [pcg_pkg::COORD_W-1:0]       rect_height_i,
  input  logic [pcg_pkg::CELL_W-1:0]        cell_col_i,
  input  logic [pcg_pkg::CELL_W-1:0]        cell_row_i,
  input  logic signed [pcg_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [pcg_pkg::COORD_W-1:0] point_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pcg_pkg::KIND_W-1:0]        result_kind_o,
  output logic [pcg_pkg::COST_W-1:0]        cost_o,
  output logic signed [pcg_pkg::GRAD_W-1:0] grad_x_o,
  output logic signed [pcg_pkg::GRAD_W-1:0] grad_y_o
);
  import pcg_pkg::*;

  pcg_cmd_t    cmd;
  pcg_status_t status;

  assign cfg_ready_o = 1'b1;

  pcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pcg_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .action_i      (action_i),
    .slot_i        (slot_i),
    .rect_left_i   (rect_left_i),
    .rect_top_i    (rect_top_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .cell_col_i    (cell_col_i),
    .cell_row_i    (cell_row_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .result_kind_o (result_kind_o),
    .cost_o        (cost_o),
    .grad_x_o      (grad_x_o),
    .grad_y_o      (grad_y_o)
  );

endmodule

[src/pcg_ram.sv]
// Generic single-write, single-read memory with registered read data.
module pcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/pcg_div.sv]
// Shared restoring divider producing one quotient bit per cycle.
module pcg_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pcg_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [pcg_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [pcg_pkg::DIV_NUM_W-1:0]  quot_o
);
  import pcg_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   rem_q;
  logic [DIV_DEN_W:0]   rem_n;
  logic                 fits;

  assign rem_n = {rem_q[DIV_DEN_W-1:0], num_q[DIV_NUM_W-1]};
  assign fits  = rem_n >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_n - {1'b0, den_q}) : rem_n;
      num_q <= {num_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

[src/pcg_dpath.sv]
// Datapath: configuration registers, rectangle and grid memories, square root and cost arithmetic.
module pcg_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [pcg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pcg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [pcg_pkg::ACT_W-1:0]       action_i,
  input  logic [pcg_pkg::SLOT_W-1:0]      slot_i,
  input  logic [pcg_pkg::COORD_W-1:0]     rect_left_i,
  input  logic [pcg_pkg::COORD_W-1:0]     rect_top_i,
  input  logic [pcg_pkg::COORD_W-1:0]     rect_width_i,
  input  logic [pcg_pkg::COORD_W-1:0]     rect_height_i,
  input  logic [pcg_pkg::CELL_W-1:0]      cell_col_i,
  input  logic [pcg_pkg::CELL_W-1:0]      cell_row_i,
  input  logic signed [pcg_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [pcg_pkg::COORD_W-1:0] point_y_i,
  input  pcg_pkg::pcg_cmd_t               cmd_i,
  output pcg_pkg::pcg_status_t            status_o,
  output logic [pcg_pkg::KIND_W-1:0]      result_kind_o,
  output logic [pcg_pkg::COST_W-1:0]      cost_o,
  output logic signed [pcg_pkg::GRAD_W-1:0] grad_x_o,
  output logic signed [pcg_pkg::GRAD_W-1:0] grad_y_o
);
  import pcg_pkg::*;

  logic [7:0]  cell_size_q, grid_cols_q, grid_rows_q;
  logic [5:0]  barrier_count_q;
  logic [15:0] near_cost_q, far_cost_q, near_dist_q, far_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q     <= RST_CELL_SIZE;
      grid_cols_q     <= '0;
      grid_rows_q     <= '0;
      barrier_count_q <= '0;
      near_cost_q     <= RST_NEAR_COST;
      far_cost_q      <= RST_FAR_COST;
      near_dist_q     <= RST_NEAR_DIST;
      far_dist_q      <= RST_FAR_DIST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CELL_SIZE:     cell_size_q     <= cfg_data_i[7:0];
        CFG_GRID_COLS:     grid_cols_q     <= cfg_data_i[7:0];
        CFG_GRID_ROWS:     grid_rows_q     <= cfg_data_i[7:0];
        CFG_BARRIER_COUNT: barrier_count_q <= cfg_data_i[5:0];
        CFG_NEAR_COST:     near_cost_q     <= cfg_data_i;
        CFG_FAR_COST:      far_cost_q      <= cfg_data_i;
        CFG_NEAR_DIST:     near_dist_q     <= cfg_data_i;
        CFG_FAR_DIST:      far_dist_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [ACT_W-1:0]   act_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [COORD_W-1:0] rl_q, rt_q, rw_q, rh_q;
  logic [CELL_W-1:0]  col_q, row_q;
  logic [COORD_W-1:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      slot_q <= slot_i;
      rl_q   <= rect_left_i;
      rt_q   <= rect_top_i;
      rw_q   <= rect_width_i;
      rh_q   <= rect_height_i;
      col_q  <= cell_col_i;
      row_q  <= cell_row_i;
      px_q   <= point_x_i;
      py_q   <= point_y_i;
    end
  end

  logic [7:0]         cell_eff;
  logic [11:0]        cell16;
  logic [10:0]        eps;
  logic [15:0]        cols_eff, rows_eff;
  logic [RECT_CW-1:0] n_eff;
  logic               is_grad, grid_empty, in_grid;

  assign cell_eff   = (cell_size_q == 8'd0) ? 8'd1 : cell_size_q;
  assign cell16     = {cell_eff, 4'b0000};
  assign eps        = {cell_eff, 3'b000};
  assign cols_eff   = (16'(grid_cols_q) > 16'(MAX_COLS)) ? 16'(MAX_COLS) : 16'(grid_cols_q);
  assign rows_eff   = (16'(grid_rows_q) > 16'(MAX_ROWS)) ? 16'(MAX_ROWS) : 16'(grid_rows_q);
  assign n_eff      = (16'(barrier_count_q) > 16'(MAX_RECTS)) ? RECT_CW'(MAX_RECTS)
                                                              : RECT_CW'(barrier_count_q);
  assign is_grad    = act_q == ACT_GRAD;
  assign grid_empty = (cols_eff == 16'd0) || (rows_eff == 16'd0);
  assign in_grid    = (16'(col_q) < cols_eff) && (16'(row_q) < rows_eff);

  // Rectangle table.
  logic [RECT_CW-1:0] i_q;
  logic [RECT_W-1:0]  rect_rdata;
  logic               rect_we;

  assign rect_we = cmd_i.rect_we && (16'(slot_q) < 16'(MAX_RECTS));

  pcg_ram #(
    .WIDTH (RECT_W),
    .DEPTH (MAX_RECTS)
  ) u_rect_ram (
    .clk_i   (clk_i),
    .we_i    (rect_we),
    .waddr_i (RECT_AW'(slot_q)),
    .wdata_i ({rl_q, rt_q, rw_q, rh_q}),
    .raddr_i (i_q[RECT_AW-1:0]),
    .rdata_o (rect_rdata)
  );

  // Distance to one rectangle.
  logic [CRD_W-1:0]   cx_q, cy_q, dx, dy;
  logic [COORD_W:0]   right, bottom;
  logic [SQ_W-1:0]    dx2_q, dy2_q;

  assign right  = {1'b0, rect_rdata[4*COORD_W-1 -: COORD_W]} + {1'b0, rect_rdata[2*COORD_W-1 -: COORD_W]};
  assign bottom = {1'b0, rect_rdata[3*COORD_W-1 -: COORD_W]} + {1'b0, rect_rdata[COORD_W-1:0]};

  always_comb begin
    if (cx_q < CRD_W'(rect_rdata[4*COORD_W-1 -: COORD_W])) begin
      dx = CRD_W'(rect_rdata[4*COORD_W-1 -: COORD_W]) - cx_q;
    end else if (cx_q > CRD_W'(right)) begin
      dx = cx_q - CRD_W'(right);
    end else begin
      dx = '0;
    end
    if (cy_q < CRD_W'(rect_rdata[3*COORD_W-1 -: COORD_W])) begin
      dy = CRD_W'(rect_rdata[3*COORD_W-1 -: COORD_W]) - cy_q;
    end else if (cy_q > CRD_W'(bottom)) begin
      dy = cy_q - CRD_W'(bottom);
    end else begin
      dy = '0;
    end
  end

  // Bit-serial integer square root.
  logic [RAD_W-1:0]      rad_q;
  logic [ROOT_W-1:0]     root_q, best_q;
  logic [SREM_W-1:0]     srem_q, srem_n, trial;
  logic [SQRT_CNT_W-1:0] scnt_q;

  assign srem_n = {srem_q[SREM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = SREM_W'({root_q, 2'b01});

  // Cost mapping.
  logic [15:0] t_q, t2_q, s_q;
  logic [32:0] p1_q;
  logic [31:0] p2_q;
  logic [33:0] s_prod;
  logic [33:0] mix_sum;
  logic [COST_W-1:0] cost_q;

  assign s_prod  = 34'(t2_q) * (34'(196608) - 34'({t_q, 1'b0}));
  assign mix_sum = 34'(p1_q) + 34'(p2_q);

  // Query probes.
  logic [1:0]          pk_q;
  logic [COL_AW-1:0]   ix_q;
  logic [ROW_AW-1:0]   iy_q;
  logic [COST_W-1:0]   pc_q [4];
  logic [COST_W-1:0]   grid_rdata;
  logic [17:0]         px_ext, py_ext, probe_x, probe_y;
  logic [15:0]         cols_m1, rows_m1;

  assign px_ext  = {{2{px_q[COORD_W-1]}}, px_q};
  assign py_ext  = {{2{py_q[COORD_W-1]}}, py_q};
  assign cols_m1 = cols_eff - 16'd1;
  assign rows_m1 = rows_eff - 16'd1;

  always_comb begin
    probe_x = px_ext;
    probe_y = py_ext;
    if (is_grad) begin
      unique case (pk_q)
        2'd0: probe_x = px_ext - 18'(eps);
        2'd1: probe_x = px_ext + 18'(eps);
        2'd2: probe_y = py_ext - 18'(eps);
        2'd3: probe_y = py_ext + 18'(eps);
        default: ;
      endcase
    end
  end

  pcg_ram #(
    .WIDTH (COST_W),
    .DEPTH (GRID_DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.grid_we && in_grid),
    .waddr_i (GRID_AW'(32'(row_q) * MAX_COLS + 32'(col_q))),
    .wdata_i (cost_q),
    .raddr_i (GRID_AW'(32'(iy_q) * MAX_COLS + 32'(ix_q))),
    .rdata_o (grid_rdata)
  );

  // Gradient differences.
  logic [24:0]         gdx, gdy;
  logic [GRAD_W-1:0]   gx10, gy10, gx_mag, gy_mag;
  logic signed [GRAD_W-1:0] gx_q, gy_q;

  assign gdx    = {1'b0, pc_q[1]} - {1'b0, pc_q[0]};
  assign gdy    = {1'b0, pc_q[3]} - {1'b0, pc_q[2]};
  assign gx10   = (GRAD_W'({{4{gdx[24]}}, gdx}) << 3) + (GRAD_W'({{4{gdx[24]}}, gdx}) << 1);
  assign gy10   = (GRAD_W'({{4{gdy[24]}}, gdy}) << 3) + (GRAD_W'({{4{gdy[24]}}, gdy}) << 1);
  assign gx_mag = gx10[GRAD_W-1] ? -gx10 : gx10;
  assign gy_mag = gy10[GRAD_W-1] ? -gy10 : gy10;

  // Shared divider.
  logic [DIV_NUM_W-1:0] div_num, quot;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_busy, div_done;

  always_comb begin
    div_num = '0;
    div_den = 16'd1;
    unique case (cmd_i.div_sel)
      DIV_T: begin
        div_num = {16'(best_q - ROOT_W'(near_dist_q)), 16'h0000};
        div_den = far_dist_q - near_dist_q;
      end
      DIV_PX: begin
        div_num = DIV_NUM_W'(probe_x[16:0]);
        div_den = DIV_DEN_W'(cell16);
      end
      DIV_PY: begin
        div_num = DIV_NUM_W'(probe_y[16:0]);
        div_den = DIV_DEN_W'(cell16);
      end
      DIV_GX: begin
        div_num = DIV_NUM_W'(gx_mag);
        div_den = DIV_DEN_W'(cell_eff);
      end
      DIV_GY: begin
        div_num = DIV_NUM_W'(gy_mag);
        div_den = DIV_DEN_W'(cell_eff);
      end
      default: ;
    endcase
  end

  pcg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Working registers.
  logic [KIND_W-1:0]        kind_q;
  logic [COST_W-1:0]        res_cost_q;
  logic signed [GRAD_W-1:0] res_gx_q, res_gy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_cell) begin
      cx_q <= CRD_W'(col_q) * CRD_W'(cell16);
      cy_q <= CRD_W'(row_q) * CRD_W'(cell16);
      i_q  <= '0;
    end else if (cmd_i.min_upd) begin
      i_q <= i_q + RECT_CW'(1);
    end
    if (cmd_i.dist_calc) begin
      dx2_q <= SQ_W'(dx) * SQ_W'(dx);
      dy2_q <= SQ_W'(dy) * SQ_W'(dy);
    end
    if (cmd_i.sqrt_init) begin
      rad_q  <= RAD_W'(dx2_q) + RAD_W'(dy2_q);
      root_q <= '0;
      srem_q <= '0;
      scnt_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      scnt_q <= scnt_q + SQRT_CNT_W'(1);
      if (srem_n >= trial) begin
        srem_q <= srem_n - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        srem_q <= srem_n;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.min_upd && ((i_q == '0) || (root_q < best_q))) begin
      best_q <= root_q;
    end
    if (cmd_i.t_load) begin
      t_q <= quot[15:0];
    end
    if (cmd_i.t2_calc) begin
      t2_q <= 16'((32'(t_q) * 32'(t_q)) >> 16);
    end
    if (cmd_i.s_calc) begin
      s_q <= (s_prod[33:16] > 18'd65535) ? 16'hFFFF : s_prod[31:16];
    end
    if (cmd_i.mix_calc) begin
      p1_q <= 33'(near_cost_q) * (33'(65536) - 33'(s_q));
      p2_q <= 32'(far_cost_q) * 32'(s_q);
    end
    if (cmd_i.cost_load) begin
      unique case (cmd_i.cost_src)
        SRC_NEAR: cost_q <= {near_cost_q, 8'h00};
        SRC_FAR:  cost_q <= {far_cost_q, 8'h00};
        SRC_MIX:  cost_q <= mix_sum[31:8];
        SRC_GRID: cost_q <= grid_rdata;
        default:  cost_q <= grid_rdata;
      endcase
    end
    if (cmd_i.probe_init) begin
      pk_q <= '0;
    end else if (cmd_i.pc_load) begin
      pk_q <= pk_q + 2'd1;
    end
    if (cmd_i.pc_load) begin
      pc_q[pk_q] <= grid_rdata;
    end
    if (cmd_i.ix_load) begin
      if (probe_x[17]) begin
        ix_q <= '0;
      end else if (quot > DIV_NUM_W'(cols_m1)) begin
        ix_q <= COL_AW'(cols_m1);
      end else begin
        ix_q <= COL_AW'(quot);
      end
    end
    if (cmd_i.iy_load) begin
      if (probe_y[17]) begin
        iy_q <= '0;
      end else if (quot > DIV_NUM_W'(rows_m1)) begin
        iy_q <= ROW_AW'(rows_m1);
      end else begin
        iy_q <= ROW_AW'(quot);
      end
    end
    if (cmd_i.gx_load) begin
      gx_q <= gx10[GRAD_W-1] ? -GRAD_W'(quot) : GRAD_W'(quot);
    end
    if (cmd_i.gy_load) begin
      gy_q <= gy10[GRAD_W-1] ? -GRAD_W'(quot) : GRAD_W'(quot);
    end
    if (cmd_i.res_load) begin
      unique case (act_q)
        ACT_COMPUTE: kind_q <= KIND_CELL;
        ACT_COST:    kind_q <= KIND_POINT;
        default:     kind_q <= KIND_GRAD;
      endcase
      res_cost_q <= is_grad ? '0 : cost_q;
      res_gx_q   <= (is_grad && !grid_empty) ? gx_q : '0;
      res_gy_q   <= (is_grad && !grid_empty) ? gy_q : '0;
    end
  end

  assign status_o.n_zero       = n_eff == '0;
  assign status_o.grid_empty   = grid_empty;
  assign status_o.rect_more    = (i_q + RECT_CW'(1)) < n_eff;
  assign status_o.sqrt_last    = scnt_q == SQRT_CNT_W'(SQRT_STEPS - 1);
  assign status_o.best_lt_near = best_q < ROOT_W'(near_dist_q);
  assign status_o.best_ge_far  = best_q >= ROOT_W'(far_dist_q);
  assign status_o.div_done     = div_done;
  assign status_o.div_busy     = div_busy;
  assign status_o.probe_last   = !is_grad || (pk_q == 2'd3);
  assign status_o.is_grad      = is_grad;

  assign result_kind_o = kind_q;
  assign cost_o        = res_cost_q;
  assign grad_x_o      = res_gx_q;
  assign grad_y_o      = res_gy_q;

endmodule

[src/pcg_ctrl.sv]
// Controller state machine sequencing loads, cell computations and queries.
module pcg_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [pcg_pkg::ACT_W-1:0]    action_i,
  output logic                         in_ready_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  input  pcg_pkg::pcg_status_t         status_i,
  output pcg_pkg::pcg_cmd_t            cmd_o
);
  import pcg_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LOAD   = 5'd1;
  localparam logic [4:0] S_CELL   = 5'd2;
  localparam logic [4:0] S_RD     = 5'd3;
  localparam logic [4:0] S_DIST   = 5'd4;
  localparam logic [4:0] S_SUM    = 5'd5;
  localparam logic [4:0] S_SQRT   = 5'd6;
  localparam logic [4:0] S_MIN    = 5'd7;
  localparam logic [4:0] S_MAP    = 5'd8;
  localparam logic [4:0] S_TDIV   = 5'd9;
  localparam logic [4:0] S_TWAIT  = 5'd10;
  localparam logic [4:0] S_T2     = 5'd11;
  localparam logic [4:0] S_S      = 5'd12;
  localparam logic [4:0] S_MIX    = 5'd13;
  localparam logic [4:0] S_SUMC   = 5'd14;
  localparam logic [4:0] S_WR     = 5'd15;
  localparam logic [4:0] S_PROBE  = 5'd16;
  localparam logic [4:0] S_XDIV   = 5'd17;
  localparam logic [4:0] S_XWAIT  = 5'd18;
  localparam logic [4:0] S_YDIV   = 5'd19;
  localparam logic [4:0] S_YWAIT  = 5'd20;
  localparam logic [4:0] S_GRD    = 5'd21;
  localparam logic [4:0] S_GRDW   = 5'd22;
  localparam logic [4:0] S_GXDIV  = 5'd23;
  localparam logic [4:0] S_GXWAIT = 5'd24;
  localparam logic [4:0] S_GYDIV  = 5'd25;
  localparam logic [4:0] S_GYWAIT = 5'd26;
  localparam logic [4:0] S_DONE   = 5'd27;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (action_i)
            ACT_LOAD:    state_d = S_LOAD;
            ACT_COMPUTE: state_d = S_CELL;
            default:     state_d = S_PROBE;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.rect_we = 1'b1;
        state_d = S_IDLE;
      end
      S_CELL: begin
        if (status_i.n_zero) begin
          cmd_o.cost_load = 1'b1;
          cmd_o.cost_src  = SRC_FAR;
          state_d = S_WR;
        end else begin
          cmd_o.init_cell = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD:   state_d = S_DIST;
      S_DIST: begin
        cmd_o.dist_calc = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sqrt_init = 1'b1;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_last) begin
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        cmd_o.min_upd = 1'b1;
        state_d = status_i.rect_more ? S_RD : S_MAP;
      end
      S_MAP: begin
        if (status_i.best_lt_near) begin
          cmd_o.cost_load = 1'b1;
          cmd_o.cost_src  = SRC_NEAR;
          state_d = S_WR;
        end else if (status_i.best_ge_far) begin
          cmd_o.cost_load = 1'b1;
          cmd_o.cost_src  = SRC_FAR;
          state_d = S_WR;
        end else begin
          state_d = S_TDIV;
        end
      end
      S_TDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_T;
        state_d = S_TWAIT;
      end
      S_TWAIT: begin
        if (status_i.div_done) begin
          cmd_o.t_load = 1'b1;
          state_d = S_T2;
        end
      end
      S_T2: begin
        cmd_o.t2_calc = 1'b1;
        state_d = S_S;
      end
      S_S: begin
        cmd_o.s_calc = 1'b1;
        state_d = S_MIX;
      end
      S_MIX: begin
        cmd_o.mix_calc = 1'b1;
        state_d = S_SUMC;
      end
      S_SUMC: begin
        cmd_o.cost_load = 1'b1;
        cmd_o.cost_src  = SRC_MIX;
        state_d = S_WR;
      end
      S_WR: begin
        cmd_o.grid_we = 1'b1;
        state_d = S_DONE;
      end
      S_PROBE: begin
        if (status_i.grid_empty) begin
          cmd_o.cost_load = 1'b1;
          cmd_o.cost_src  = SRC_FAR;
          state_d = S_DONE;
        end else begin
          cmd_o.probe_init = 1'b1;
          state_d = S_XDIV;
        end
      end
      S_XDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_PX;
        state_d = S_XWAIT;
      end
      S_XWAIT: begin
        cmd_o.div_sel = DIV_PX;
        if (status_i.div_done) begin
          cmd_o.ix_load = 1'b1;
          state_d = S_YDIV;
        end
      end
      S_YDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_PY;
        state_d = S_YWAIT;
      end
      S_YWAIT: begin
        cmd_o.div_sel = DIV_PY;
        if (status_i.div_done) begin
          cmd_o.iy_load = 1'b1;
          state_d = S_GRD;
        end
      end
      S_GRD:  state_d = S_GRDW;
      S_GRDW: begin
        cmd_o.pc_load = 1'b1;
        if (!status_i.probe_last) begin
          state_d = S_XDIV;
        end else if (status_i.is_grad) begin
          state_d = S_GXDIV;
        end else begin
          cmd_o.cost_load = 1'b1;
          cmd_o.cost_src  = SRC_GRID;
          state_d = S_DONE;
        end
      end
      S_GXDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_GX;
        state_d = S_GXWAIT;
      end
      S_GXWAIT: begin
        if (status_i.div_done) begin
          cmd_o.gx_load = 1'b1;
          state_d = S_GYDIV;
        end
      end
      S_GYDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_GY;
        state_d = S_GYWAIT;
      end
      S_GYWAIT: begin
        if (status_i.div_done) begin
          cmd_o.gy_load = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !status_i.div_busy)
    else $error("Divider started while still busy.");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_TWAIT || state_q == S_XWAIT ||
                           state_q == S_YWAIT || state_q == S_GXWAIT ||
                           state_q == S_GYWAIT))
    else $error("Divider finished with no state waiting for it.");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("Result presented without a finished transaction.");

  a_stall_holds_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> state_q == S_DONE)
    else $error("Pending result overwritten while the receiver stalls.");

endmodule

[dv/proximity_cost_grid_checker.sv]
// Checker of the proximity cost grid: tracks configuration, predicts each result and compares.
module proximity_cost_grid_checker
  import pcg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [ACT_W-1:0]          action_i,
  input  logic [SLOT_W-1:0]         slot_i,
  input  logic [COORD_W-1:0]        rect_left_i,
  input  logic [COORD_W-1:0]        rect_top_i,
  input  logic [COORD_W-1:0]        rect_width_i,
  input  logic [COORD_W-1:0]        rect_height_i,
  input  logic [CELL_W-1:0]         cell_col_i,
  input  logic [CELL_W-1:0]         cell_row_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [KIND_W-1:0]         result_kind_i,
  input  logic [COST_W-1:0]         cost_i,
  input  logic signed [GRAD_W-1:0]  grad_x_i,
  input  logic signed [GRAD_W-1:0]  grad_y_i,
  output int                        mismatches_o,
  output int                        outstanding_o
);

  typedef struct {
    kind_e                    kind;
    logic [COST_W-1:0]        cost;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } cost_result_t;

  cost_result_t awaited_results[$];

  logic [15:0] rect_l [MAX_RECTS];
  logic [15:0] rect_t [MAX_RECTS];
  logic [15:0] rect_w [MAX_RECTS];
  logic [15:0] rect_h [MAX_RECTS];
  logic [COST_W-1:0] grid_copy [GRID_DEPTH];

  logic [7:0]  cell_size, grid_cols, grid_rows;
  logic [5:0]  barriers;
  logic [15:0] near_cost, far_cost, near_dist, far_dist;

  assign outstanding_o = awaited_results.size();

  function automatic longint span();
    return (cell_size == 0) ? 1 : longint'(cell_size);
  endfunction

  function automatic longint used_cols();
    return (grid_cols > MAX_COLS) ? MAX_COLS : longint'(grid_cols);
  endfunction

  function automatic longint used_rows();
    return (grid_rows > MAX_ROWS) ? MAX_ROWS : longint'(grid_rows);
  endfunction

  function automatic longint limit_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint floor_root(longint v);
    longint r;
    longint cand;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      cand = r | (longint'(1) << b);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  function automatic logic [COST_W-1:0] proximity_cost(longint col, longint row);
    longint n, cx, cy, qx, qy, dx, dy, d, nearest, t, t2, s;
    n = (barriers > MAX_RECTS) ? MAX_RECTS : longint'(barriers);
    cx = col * span() * 16;
    cy = row * span() * 16;
    nearest = 0;
    if (n == 0) return {far_cost, 8'h00};
    for (int i = 0; i < n; i++) begin
      qx = limit_to(cx, rect_l[i], longint'(rect_l[i]) + rect_w[i]);
      qy = limit_to(cy, rect_t[i], longint'(rect_t[i]) + rect_h[i]);
      dx = cx - qx;
      dy = cy - qy;
      d = floor_root(dx * dx + dy * dy);
      if (i == 0 || d < nearest) nearest = d;
    end
    if (nearest < near_dist) return {near_cost, 8'h00};
    if (nearest >= far_dist) return {far_cost, 8'h00};
    t = ((nearest - near_dist) << 16) / (longint'(far_dist) - near_dist);
    if (t > 65535) t = 65535;
    t2 = (t * t) >> 16;
    s = (t2 * (3 * 65536 - 2 * t)) >> 16;
    if (s > 65535) s = 65535;
    return COST_W'((longint'(near_cost) * (65536 - s) + longint'(far_cost) * s) >> 8);
  endfunction

  function automatic longint stored_cost(longint x, longint y);
    longint div, ix, iy;
    div = span() * 16;
    if (used_cols() == 0 || used_rows() == 0) return longint'(far_cost) << 8;
    ix = limit_to(x / div, 0, used_cols() - 1);
    iy = limit_to(y / div, 0, used_rows() - 1);
    return grid_copy[iy * MAX_COLS + ix];
  endfunction

  function automatic logic signed [GRAD_W-1:0] slope(longint hi, longint lo);
    return GRAD_W'(limit_to(((hi - lo) * 10) / span(), -268435456, 268435455));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cost_result_t want;
    cost_result_t got;
    longint px, py, half;
    if (!rst_ni) begin
      cell_size <= RST_CELL_SIZE;
      grid_cols <= '0;
      grid_rows <= '0;
      barriers  <= '0;
      near_cost <= RST_NEAR_COST;
      far_cost  <= RST_FAR_COST;
      near_dist <= RST_NEAR_DIST;
      far_dist  <= RST_FAR_DIST;
      mismatches_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CELL_SIZE:     cell_size <= cfg_data_i[7:0];
          CFG_GRID_COLS:     grid_cols <= cfg_data_i[7:0];
          CFG_GRID_ROWS:     grid_rows <= cfg_data_i[7:0];
          CFG_BARRIER_COUNT: barriers  <= cfg_data_i[5:0];
          CFG_NEAR_COST:     near_cost <= cfg_data_i;
          CFG_FAR_COST:      far_cost  <= cfg_data_i;
          CFG_NEAR_DIST:     near_dist <= cfg_data_i;
          CFG_FAR_DIST:      far_dist  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = '{kind_e'(result_kind_i), cost_i, grad_x_i, grad_y_i};
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d cost %0d gx %0d gy %0d", $time,
                   got.kind, got.cost, got.gx, got.gy);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got.kind != want.kind || got.cost != want.cost || got.gx != want.gx ||
              got.gy != want.gy) begin
            $display("%0t: expected kind %0d cost %0d gx %0d gy %0d, got %0d %0d %0d %0d",
                     $time, want.kind, want.cost, want.gx, want.gy,
                     got.kind, got.cost, got.gx, got.gy);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        px = point_x_i;
        py = point_y_i;
        want = '{KIND_CELL, '0, '0, '0};
        case (action_e'(action_i))
          ACT_LOAD: begin
            rect_l[slot_i] = rect_left_i;
            rect_t[slot_i] = rect_top_i;
            rect_w[slot_i] = rect_width_i;
            rect_h[slot_i] = rect_height_i;
          end
          ACT_COMPUTE: begin
            want.cost = proximity_cost(cell_col_i, cell_row_i);
            if (cell_col_i < used_cols() && cell_row_i < used_rows())
              grid_copy[cell_row_i * MAX_COLS + cell_col_i] = want.cost;
          end
          ACT_COST: begin
            want.kind = KIND_POINT;
            want.cost = COST_W'(stored_cost(px, py));
          end
          default: begin
            want.kind = KIND_GRAD;
            if (used_cols() != 0 && used_rows() != 0) begin
              half = span() * 8;
              want.gx = slope(stored_cost(px + half, py), stored_cost(px - half, py));
              want.gy = slope(stored_cost(px, py + half), stored_cost(px, py - half));
            end
          end
        endcase
        if (action_e'(action_i) != ACT_LOAD) awaited_results.push_back(want);
      end
    end
  end

endmodule

[dv/proximity_cost_grid_test.sv]
// Testbench top of the proximity cost grid: stimulus, idling, watchdog and verdict.
module proximity_cost_grid_test;
  import pcg_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 80;

  typedef struct {
    action_e            act;
    logic [4:0]         slot;
    logic [15:0]        left, top, width, height;
    logic [6:0]         col, row;
    logic signed [15:0] px, py;
  } grid_op_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [ACT_W-1:0] action;
  logic [SLOT_W-1:0] slot;
  logic [COORD_W-1:0] rect_left, rect_top, rect_width, rect_height;
  logic [CELL_W-1:0] cell_col, cell_row;
  logic signed [COORD_W-1:0] point_x, point_y;
  logic out_valid, out_ready;
  logic [KIND_W-1:0] result_kind;
  logic [COST_W-1:0] cost;
  logic signed [GRAD_W-1:0] grad_x, grad_y;
  int mismatches, outstanding;

  int in_idle_pct, out_idle_pct;
  int quiet;
  logic [15:0] setting [8];
  bit computed [GRID_DEPTH];

  logic [15:0] plan [6][8] = '{
    '{16'd10, 16'd4, 16'd4, 16'd2, 16'd10000, 16'd1, 16'd80, 16'd1280},
    '{16'd1, 16'd128, 16'd128, 16'd32, 16'd65535, 16'd0, 16'd0, 16'd65535},
    '{16'd255, 16'd3, 16'd2, 16'd1, 16'd0, 16'd65535, 16'd65534, 16'd65535},
    '{16'd0, 16'd200, 16'd255, 16'd63, 16'd500, 16'd7000, 16'd100, 16'd3000},
    '{16'd37, 16'd1, 16'd1, 16'd5, 16'd1234, 16'd4321, 16'd16, 16'd4000},
    '{16'd10, 16'd0, 16'd5, 16'd3, 16'd300, 16'd9000, 16'd200, 16'd900}
  };

  proximity_cost_grid dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .slot_i(slot),
    .rect_left_i(rect_left), .rect_top_i(rect_top),
    .rect_width_i(rect_width), .rect_height_i(rect_height),
    .cell_col_i(cell_col), .cell_row_i(cell_row),
    .point_x_i(point_x), .point_y_i(point_y),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .result_kind_o(result_kind), .cost_o(cost),
    .grad_x_o(grad_x), .grad_y_o(grad_y)
  );

  proximity_cost_grid_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .action_i(action), .slot_i(slot),
    .rect_left_i(rect_left), .rect_top_i(rect_top),
    .rect_width_i(rect_width), .rect_height_i(rect_height),
    .cell_col_i(cell_col), .cell_row_i(cell_row),
    .point_x_i(point_x), .point_y_i(point_y),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .result_kind_i(result_kind), .cost_i(cost),
    .grad_x_i(grad_x), .grad_y_i(grad_y),
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= out_idle_pct);

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("proximity_cost_grid: mismatch");
        $finish;
      end
    end
  end

  function automatic longint span();
    return (setting[CFG_CELL_SIZE] == 0) ? 1 : longint'(setting[CFG_CELL_SIZE]);
  endfunction

  function automatic longint used_cols();
    return (setting[CFG_GRID_COLS] > MAX_COLS) ? MAX_COLS : longint'(setting[CFG_GRID_COLS]);
  endfunction

  function automatic longint used_rows();
    return (setting[CFG_GRID_ROWS] > MAX_ROWS) ? MAX_ROWS : longint'(setting[CFG_GRID_ROWS]);
  endfunction

  function automatic bit cell_ready(longint x, longint y);
    longint ix, iy;
    ix = x / (span() * 16);
    iy = y / (span() * 16);
    ix = (ix < 0) ? 0 : ((ix > used_cols() - 1) ? used_cols() - 1 : ix);
    iy = (iy < 0) ? 0 : ((iy > used_rows() - 1) ? used_rows() - 1 : iy);
    return computed[iy * MAX_COLS + ix];
  endfunction

  function automatic bit query_safe(grid_op_t op);
    longint half;
    half = span() * 8;
    if (used_cols() == 0 || used_rows() == 0) return 1'b1;
    if (op.act == ACT_COST) return cell_ready(op.px, op.py);
    return cell_ready(op.px - half, op.py) && cell_ready(op.px + half, op.py) &&
           cell_ready(op.px, op.py - half) && cell_ready(op.px, op.py + half);
  endfunction

  task automatic send_op(grid_op_t op);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= op.act;
    slot        <= op.slot;
    rect_left   <= op.left;
    rect_top    <= op.top;
    rect_width  <= op.width;
    rect_height <= op.height;
    cell_col    <= op.col;
    cell_row    <= op.row;
    point_x     <= op.px;
    point_y     <= op.py;
    do @(posedge clk); while (!in_ready);
    if (op.act == ACT_COMPUTE && op.col < used_cols() && op.row < used_rows())
      computed[op.row * MAX_COLS + op.col] = 1'b1;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic apply_setting(int p);
    settle();
    for (int i = 0; i < 8; i++) begin
      setting[i] = plan[p][i];
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= plan[p][i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic grid_op_t blank_op(action_e act);
    grid_op_t op;
    op = '{act, 5'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom), 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom)};
    return op;
  endfunction

  function automatic grid_op_t random_op();
    grid_op_t op;
    int pick;
    longint div;
    pick = $urandom_range(0, 99);
    div = span() * 16;
    if (pick < 15) return blank_op(ACT_LOAD);
    if (pick >= 35) begin
      op = blank_op(pick < 65 ? ACT_COST : ACT_GRAD);
      for (int tries = 0; tries < 20; tries++) begin
        if ($urandom_range(0, 1)) begin
          op.px = 16'($urandom_range(0, 4 * div) - div / 2);
          op.py = 16'($urandom_range(0, 4 * div) - div / 2);
        end else begin
          op.px = 16'($urandom);
          op.py = 16'($urandom);
        end
        if (query_safe(op)) return op;
      end
    end
    op = blank_op(ACT_COMPUTE);
    if ($urandom_range(0, 1) && used_cols() != 0 && used_rows() != 0) begin
      op.col = 7'($urandom_range(0, used_cols() - 1));
      op.row = 7'($urandom_range(0, used_rows() - 1));
    end
    return op;
  endfunction

  initial begin
    grid_op_t op;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    action    <= ACT_LOAD;
    slot      <= '0;
    rect_left <= '0;
    rect_top  <= '0;
    rect_width  <= '0;
    rect_height <= '0;
    cell_col  <= '0;
    cell_row  <= '0;
    point_x   <= '0;
    point_y   <= '0;
    out_ready <= 1'b0;
    quiet     <= 0;
    in_idle_pct  = 8;
    out_idle_pct = 56;
    setting = '{16'd10, 16'd0, 16'd0, 16'd0, 16'd10000, 16'd1, 16'd80, 16'd1280};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no rectangles in use and an empty grid.
    op = blank_op(ACT_COMPUTE);
    op.col = '0; op.row = '0;
    send_op(op);
    op.col = '1; op.row = '1;
    send_op(op);
    op = blank_op(ACT_COST);
    op.px = 16'sh8000; op.py = 16'sh7fff;
    send_op(op);
    op.px = 16'sh7fff; op.py = 16'sh8000;
    send_op(op);
    op = blank_op(ACT_GRAD);
    op.px = 16'sh8000; op.py = 16'sh8000;
    send_op(op);
    op.px = 16'sh7fff; op.py = 16'sh7fff;
    send_op(op);
    for (int s = 0; s < MAX_RECTS; s++) begin
      op = blank_op(ACT_LOAD);
      op.slot = 5'(s);
      case (s)
        0: begin op.left = '0; op.top = '0; op.width = '0; op.height = '0; end
        1: begin op.left = '1; op.top = '1; op.width = '1; op.height = '1; end
        2: begin op.left = '0; op.top = '0; op.width = '1; op.height = '1; end
        3: begin op.left = 16'd400; op.top = 16'd300; op.width = 16'd50; op.height = '0; end
        default: ;
      endcase
      send_op(op);
    end

    for (int p = 0; p < PHASES; p++) begin
      in_idle_pct  = (p < 4) ? 8 : ((p < 8) ? 56 : 0);
      out_idle_pct = (p < 4) ? 56 : ((p < 8) ? 8 : 0);
      apply_setting(p % 6);
      for (int r = 0; r < 4 && r < used_rows(); r++) begin
        for (int c = 0; c < 4 && c < used_cols(); c++) begin
          op = blank_op(ACT_COMPUTE);
          op.col = 7'(c);
          op.row = 7'(r);
          send_op(op);
        end
      end
      for (int k = 0; k < PHASE_ITEMS; k++) send_op(random_op());
    end

    settle();
    repeat (400) @(posedge clk);
    if (mismatches == 0) begin
      $display("proximity_cost_grid: match");
    end else begin
      $display("proximity_cost_grid: mismatch");
    end
    $finish;
  end

endmodule

[proximity_cost_grid.f]
src/pcg_pkg.sv
src/pcg_ram.sv
src/pcg_div.sv
src/pcg_dpath.sv
src/pcg_ctrl.sv
src/proximity_cost_grid.sv
dv/proximity_cost_grid_checker.sv
dv/proximity_cost_grid_test.sv
